/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL files that check their own logic.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/nsp_pkg.sv */
`timescale 1ns / 1ps

package nsp_pkg;

  localparam int MAX_DATA_LEN = 128;
  localparam int MAX_FIELDS   = 32;

  localparam int FILL_W  = $clog2(MAX_DATA_LEN);
  localparam int FIELD_W = $clog2(MAX_FIELDS + 1);

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_SEP   = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 136;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [1:0] {
    ST_PARSING  = 2'd0,
    ST_PARSED   = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BADSUM   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_HEX_HI = 4'b0100,
    PH_HEX_LO = 4'b1000
  } phase_t;

  // Classification of one received character.
  typedef struct packed {
    logic       is_start;
    logic       is_sep;
    logic       is_star;
    logic       is_eol;
    logic       hex_ok;
    logic [3:0] hex_val;
  } char_class_t;

  // One result item.
  typedef struct packed {
    status_t     status;
    logic        write_valid;
    logic [6:0]  write_index;
    logic [7:0]  write_byte;
    logic [5:0]  arg_count;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;
    logic [31:0] byte_count;
    logic [31:0] sentence_count;
    logic [31:0] error_count;
  } result_t;

endpackage

/* hw/rtl/nsp_char_decode.sv */
`timescale 1ns / 1ps

module nsp_char_decode
  import nsp_pkg::*;
(
  input  logic [7:0]  rx_byte,
  output char_class_t cls
);

  logic is_dec;
  logic is_hex_alpha;

  assign is_dec       = (rx_byte >= CH_0) && (rx_byte <= CH_9);
  assign is_hex_alpha = (rx_byte >= CH_A) && (rx_byte <= CH_F);

  always_comb begin
    cls.is_start = (rx_byte == CH_START);
    cls.is_sep   = (rx_byte == CH_SEP);
    cls.is_star  = (rx_byte == CH_STAR);
    cls.is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    cls.hex_ok   = is_dec || is_hex_alpha;
    if (is_dec) begin
      cls.hex_val = 4'(rx_byte - CH_0);
    end else if (is_hex_alpha) begin
      cls.hex_val = 4'(rx_byte - CH_A + 8'd10);
    end else begin
      cls.hex_val = 4'd0;
    end
  end

endmodule

/* hw/rtl/nsp_parse_core.sv */
`timescale 1ns / 1ps

module nsp_parse_core
  import nsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  rx_byte,
  input  char_class_t cls,
  output result_t     res
);

  phase_t              phase_r, phase_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [FIELD_W-1:0]  fields_r, fields_nxt;
  logic [7:0]          xor_r, xor_nxt;
  logic [7:0]          hex_r, hex_nxt;
  logic [31:0]         bytes_r, bytes_nxt;
  logic [31:0]         sent_r, sent_nxt;
  logic [31:0]         err_r, err_nxt;

  status_t             status;
  logic                wr_valid;
  logic [FILL_W-1:0]   wr_index;
  logic [7:0]          wr_byte;
  logic                buf_last;
  logic                fields_full;
  logic [7:0]          hex_lo_val;

  // Fill position at the last buffer entry: the write lands but no room stays.
  assign buf_last    = (fill_r == FILL_W'(MAX_DATA_LEN - 1));
  assign fields_full = (fields_r >= FIELD_W'(MAX_FIELDS));
  assign hex_lo_val  = hex_r | {4'd0, cls.hex_val};

  always_comb begin
    phase_nxt  = phase_r;
    fill_nxt   = fill_r;
    fields_nxt = fields_r;
    xor_nxt    = xor_r;
    hex_nxt    = hex_r;
    bytes_nxt  = bytes_r + 32'd1;
    sent_nxt   = sent_r;
    err_nxt    = err_r;
    status     = ST_PARSING;
    wr_valid   = 1'b0;
    wr_index   = '0;
    wr_byte    = 8'd0;

    case (phase_r)
      PH_SEARCH: begin
        if (cls.is_start) begin
          fill_nxt   = '0;
          fields_nxt = FIELD_W'(1);
          xor_nxt    = 8'd0;
          hex_nxt    = 8'd0;
          phase_nxt  = PH_DATA;
        end
      end
      PH_DATA: begin
        if (cls.is_sep) begin
          if (fields_full) begin
            phase_nxt = PH_SEARCH;
            err_nxt   = err_r + 32'd1;
            status    = ST_OVERFLOW;
          end else begin
            wr_valid = 1'b1;
            wr_index = fill_r;
            fill_nxt = fill_r + FILL_W'(1);
            if (buf_last) begin
              phase_nxt = PH_SEARCH;
              err_nxt   = err_r + 32'd1;
              status    = ST_OVERFLOW;
            end else begin
              xor_nxt    = xor_r ^ rx_byte;
              fields_nxt = fields_r + FIELD_W'(1);
            end
          end
        end else if (cls.is_star) begin
          wr_valid  = 1'b1;
          wr_index  = fill_r;
          phase_nxt = PH_HEX_HI;
        end else if (cls.is_eol) begin
          wr_valid  = 1'b1;
          wr_index  = fill_r;
          sent_nxt  = sent_r + 32'd1;
          phase_nxt = PH_SEARCH;
          status    = ST_PARSED;
        end else begin
          wr_valid = 1'b1;
          wr_index = fill_r;
          wr_byte  = rx_byte;
          fill_nxt = fill_r + FILL_W'(1);
          xor_nxt  = xor_r ^ rx_byte;
          if (buf_last) begin
            phase_nxt = PH_SEARCH;
            err_nxt   = err_r + 32'd1;
            status    = ST_OVERFLOW;
          end
        end
      end
      PH_HEX_HI: begin
        if (cls.hex_ok) begin
          hex_nxt   = hex_r | {cls.hex_val, 4'd0};
          phase_nxt = PH_HEX_LO;
        end else begin
          phase_nxt = PH_SEARCH;
          err_nxt   = err_r + 32'd1;
          status    = ST_BADSUM;
        end
      end
      PH_HEX_LO: begin
        if (cls.hex_ok) begin
          hex_nxt = hex_lo_val;
        end
        if (cls.hex_ok && (xor_r == hex_lo_val)) begin
          sent_nxt = sent_r + 32'd1;
          status   = ST_PARSED;
        end else begin
          err_nxt = err_r + 32'd1;
          status  = ST_BADSUM;
        end
        phase_nxt = PH_SEARCH;
      end
      default: begin
        phase_nxt = PH_SEARCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SEARCH;
      fill_r   <= '0;
      fields_r <= '0;
      xor_r    <= 8'd0;
      hex_r    <= 8'd0;
      bytes_r  <= 32'd0;
      sent_r   <= 32'd0;
      err_r    <= 32'd0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      fill_r   <= fill_nxt;
      fields_r <= fields_nxt;
      xor_r    <= xor_nxt;
      hex_r    <= hex_nxt;
      bytes_r  <= bytes_nxt;
      sent_r   <= sent_nxt;
      err_r    <= err_nxt;
    end
  end

  always_comb begin
    res.status            = status;
    res.write_valid       = wr_valid;
    res.write_index       = 7'(wr_index);
    res.write_byte        = wr_byte;
    res.arg_count         = 6'(fields_nxt);
    res.computed_checksum = xor_nxt;
    res.received_checksum = hex_nxt;
    res.byte_count        = bytes_nxt;
    res.sentence_count    = sent_nxt;
    res.error_count       = err_nxt;
  end

endmodule

/* hw/rtl/nsp_out_stage.sv */
`timescale 1ns / 1ps

module nsp_out_stage
  import nsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  input  logic    out_ready,
  output logic    advance,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Free slot, or the waiting item leaves this cycle.
  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* hw/rtl/nmea_sentence_parser_top.sv */
// NMEA 0183 sentence parser, one received byte in, one result item out.
// Path: the input register captures the byte at the accept edge, the result register
// captures its result item once the result slot can take it, and the item leaves at out_tready.
// Throughput: one item per cycle while out_tready keeps the result slot free.
// Reset (rst_n low, synchronous): parser returns to start search, counters and
// checksums clear, both pipeline valid flags drop.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nmea_sentence_parser_top
  import nsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [6:0] write_index, [14:7] write_byte, [20:15] arg_count,
  // [28:21] computed_checksum, [36:29] received_checksum, [68:37] byte_count,
  // [100:69] sentence_count, [132:101] error_count, [135:133] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status, [2] write_valid
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        advance;
  logic        fire;
  char_class_t cls;
  result_t     res;
  result_t     out_res;

  // Stage 2 runs when a byte waits and the result slot can take it.
  assign fire      = in_valid_r && advance;
  // Take a new byte when the input register is empty or drains this cycle.
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Payload needs no reset: hold it until the next accept.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata[7:0];
    end
  end

  nsp_char_decode u_decode (
    .rx_byte (in_byte_r),
    .cls     (cls)
  );

  nsp_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (in_byte_r),
    .cls     (cls),
    .res     (res)
  );

  nsp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (res),
    .out_ready (out_tready),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_res   (out_res)
  );

  // Pack the result item onto the stream bus.
  assign out_tuser = {out_res.write_valid, out_res.status};
  assign out_tdata = {3'b000,
                      out_res.error_count,
                      out_res.sentence_count,
                      out_res.byte_count,
                      out_res.received_checksum,
                      out_res.computed_checksum,
                      out_res.arg_count,
                      out_res.write_byte,
                      out_res.write_index};

  // A checksum failure never touches the sentence buffer.
  `ASSERT_IMPL(a_badsum_no_write, out_tvalid && (out_tuser[1:0] == ST_BADSUM), !out_tuser[2])
  // Every parse step lands in the result register.
  `ASSERT_NEXT(a_fire_gives_result, fire, out_tvalid)
  // A stalled byte stays in the input register untouched.
  `ASSERT_NEXT(a_in_hold, in_valid_r && !advance, in_valid_r && $stable(in_byte_r))

endmodule

/* tb/nmea_result_checker.sv */
`timescale 1ns / 1ps

module nmea_result_checker
  import nsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  output int                     fail_count,
  output int                     awaited_count,
  output int                     checked_count
);

  // Parser state as seen from the byte stream.
  phase_t      scan_phase;
  int unsigned buf_fill;
  int unsigned field_num;
  logic [7:0]  xor_sum;
  logic [7:0]  sum_digits;
  logic [31:0] byte_total;
  logic [31:0] parsed_total;
  logic [31:0] error_total;

  result_t awaited_results[$];

  // Bit 4 flags an upper-case hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return {1'b1, 4'(c - CH_0)};
    if (c >= CH_A && c <= CH_F) return {1'b1, 4'(c - CH_A + 8'd10)};
    return 5'b0;
  endfunction

  function automatic void stage_write(inout result_t r, input logic [7:0] b);
    r.write_valid = 1'b1;
    r.write_index = buf_fill[6:0];
    r.write_byte  = b;
  endfunction

  // Abandon the sentence and go back to hunting for a start.
  function automatic void drop_sentence(inout result_t r, input status_t why);
    r.status   = why;
    error_total++;
    scan_phase = PH_SEARCH;
  endfunction

  function automatic result_t parse_rx_byte(input logic [7:0] rx);
    result_t    r;
    logic [4:0] digit;
    r        = '0;
    r.status = ST_PARSING;
    digit    = hex_of(rx);
    byte_total++;
    case (scan_phase)
      PH_SEARCH: begin
        if (rx == CH_START) begin
          buf_fill   = 0;
          field_num  = 1;
          xor_sum    = 8'h00;
          sum_digits = 8'h00;
          scan_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (rx == CH_SEP) begin
          if (field_num >= MAX_FIELDS) begin
            drop_sentence(r, ST_OVERFLOW);
          end else begin
            stage_write(r, 8'h00);
            buf_fill++;
            if (buf_fill >= MAX_DATA_LEN) begin
              drop_sentence(r, ST_OVERFLOW);
            end else begin
              xor_sum ^= rx;
              field_num++;
            end
          end
        end else if (rx == CH_STAR) begin
          stage_write(r, 8'h00);
          scan_phase = PH_HEX_HI;
        end else if (rx == CH_CR || rx == CH_LF) begin
          stage_write(r, 8'h00);
          parsed_total++;
          scan_phase = PH_SEARCH;
          r.status   = ST_PARSED;
        end else begin
          stage_write(r, rx);
          buf_fill++;
          xor_sum ^= rx;
          if (buf_fill >= MAX_DATA_LEN) drop_sentence(r, ST_OVERFLOW);
        end
      end
      PH_HEX_HI: begin
        if (digit[4]) begin
          sum_digits |= {digit[3:0], 4'h0};
          scan_phase = PH_HEX_LO;
        end else begin
          drop_sentence(r, ST_BADSUM);
        end
      end
      default: begin
        if (digit[4]) sum_digits |= {4'h0, digit[3:0]};
        if (digit[4] && xor_sum == sum_digits) begin
          parsed_total++;
          r.status = ST_PARSED;
        end else begin
          drop_sentence(r, ST_BADSUM);
        end
        scan_phase = PH_SEARCH;
      end
    endcase
    r.arg_count         = field_num[5:0];
    r.computed_checksum = xor_sum;
    r.received_checksum = sum_digits;
    r.byte_count        = byte_total;
    r.sentence_count    = parsed_total;
    r.error_count       = error_total;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst_n) begin
      scan_phase   = PH_SEARCH;
      buf_fill     = 0;
      field_num    = 0;
      xor_sum      = 8'h00;
      sum_digits   = 8'h00;
      byte_total   = '0;
      parsed_total = '0;
      error_total  = '0;
      awaited_results.delete();
    end else begin
      if (in_tvalid && in_tready) awaited_results.push_back(parse_rx_byte(in_tdata[7:0]));
      if (out_tvalid && out_tready) begin
        seen.status            = status_t'(out_tuser[1:0]);
        seen.write_valid       = out_tuser[2];
        seen.write_index       = out_tdata[6:0];
        seen.write_byte        = out_tdata[14:7];
        seen.arg_count         = out_tdata[20:15];
        seen.computed_checksum = out_tdata[28:21];
        seen.received_checksum = out_tdata[36:29];
        seen.byte_count        = out_tdata[68:37];
        seen.sentence_count    = out_tdata[100:69];
        seen.error_count       = out_tdata[132:101];
        if (awaited_results.size() == 0) begin
          $error("result item arrived with no input item outstanding");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(seen.status));
          check_field("write_valid", 32'(want.write_valid), 32'(seen.write_valid));
          check_field("write_index", 32'(want.write_index), 32'(seen.write_index));
          check_field("write_byte", 32'(want.write_byte), 32'(seen.write_byte));
          check_field("arg_count", 32'(want.arg_count), 32'(seen.arg_count));
          check_field("computed_checksum", 32'(want.computed_checksum),
                      32'(seen.computed_checksum));
          check_field("received_checksum", 32'(want.received_checksum),
                      32'(seen.received_checksum));
          check_field("byte_count", want.byte_count, seen.byte_count);
          check_field("sentence_count", want.sentence_count, seen.sentence_count);
          check_field("error_count", want.error_count, seen.error_count);
          checked_count++;
        end
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

/* tb/nmea_sentence_parser_top_test.sv */
`timescale 1ns / 1ps

module nmea_sentence_parser_top_test;
  import nsp_pkg::*;

  // Random part stops once this many bytes past the opening ones were taken.
  localparam int RANDOM_BYTES   = 1400;
  // Cycles with no item moving on either side before the run is abandoned.
  // The slowest legal stretch is the squeeze below plus a long sender gap.
  localparam int STALL_LIMIT    = 1000;
  // Covers the input and result registers of the pipeline, with margin.
  localparam int DRAIN_CYCLES   = 10;
  localparam int SQUEEZE_AT     = 500;
  localparam int SQUEEZE_CYCLES = 150;

  typedef enum int {
    LK_CHECKED,
    LK_PLAIN,
    LK_WRONG_SUM,
    LK_BAD_DIGIT,
    LK_MANY_FIELDS,
    LK_LONG,
    LK_NOISE
  } line_kind_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int fail_count;
  int awaited_count;
  int checked_count;

  int         bytes_sent;
  bit         eager_line;
  int         line_tally [7];
  logic [7:0] line_bytes[$];
  logic [7:0] line_sum;

  // Opening bytes, one case after another:
  //  - both byte extremes while hunting, then a sentence whose data holds the
  //    extremes and an inner '$', closed by a good "F7" checksum
  //  - a sentence ended by CR with no checksum
  //  - a bad first hex digit (lower-case), then a bad second digit
  //  - a checksum built from '3' and 'A' that misses the running XOR of '9'
  logic [7:0] opening_bytes [25] = '{
    8'h00, 8'hFF, CH_START, 8'hFF, 8'h00, CH_START, CH_SEP, CH_STAR, CH_F, 8'h37,
    CH_START, CH_A, CH_CR,
    CH_START, CH_STAR, 8'h67,
    CH_START, CH_STAR, CH_0, 8'h61,
    CH_START, CH_9, CH_STAR, 8'h33, CH_A
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nmea_sentence_parser_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  nmea_result_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .awaited_count(awaited_count),
    .checked_count(checked_count)
  );

  // Idle length: mostly none, often a few cycles, now and then a long one.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sentence content: mostly printable, sometimes any byte. Remap the
  // delimiters so they only show up where a line is built to have them.
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
    if (c == CH_SEP || c == CH_STAR || c == CH_CR || c == CH_LF) c ^= 8'h40;
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_0 + 8'(n) : CH_A + 8'(n) - 8'd10;
  endfunction

  // Anything but an upper-case hex digit, lower-case a-f favored.
  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do begin
      c = $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h66)) : 8'($urandom_range(0, 255));
    end while ((c >= CH_0 && c <= CH_9) || (c >= CH_A && c <= CH_F));
    return c;
  endfunction

  // Append a byte that counts toward the sentence checksum.
  function automatic void add_body(input logic [7:0] c);
    line_bytes.push_back(c);
    line_sum ^= c;
  endfunction

  // Offer one byte, starting and ending at a falling edge. Hold valid high
  // across back-to-back items; drop it only for a gap.
  task automatic send_rx_byte(input logic [7:0] b);
    int gap;
    gap = eager_line ? 0 : idle_span();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Receiver: ready bursts of random length with short or long stalls in
  // between. Once, part way through, hold off long enough for the parser
  // to back up and stall the sender.
  initial begin
    int stall;
    bit squeezed;
    squeezed = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!squeezed && bytes_sent >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        out_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat (($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 4))
          @(negedge clk);
        stall = idle_span();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  // Watchdog: abandon the run when nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $error("no item moved for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    line_kind_t kind;
    int         pick;
    int         nfields;
    int         body_len;
    logic [7:0] sent_sum;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening_bytes[i]) send_rx_byte(opening_bytes[i]);

    // Random part: mostly well-formed sentences with random content, the
    // rest broken sentences and raw noise.
    while (bytes_sent < RANDOM_BYTES + 25) begin
      pick = $urandom_range(0, 99);
      kind = pick < 40 ? LK_CHECKED :
             pick < 55 ? LK_PLAIN :
             pick < 63 ? LK_WRONG_SUM :
             pick < 71 ? LK_BAD_DIGIT :
             pick < 75 ? LK_MANY_FIELDS :
             pick < 77 ? LK_LONG : LK_NOISE;
      line_tally[kind]++;
      eager_line = ($urandom_range(0, 3) == 0);
      line_bytes.delete();
      line_sum = 8'h00;

      // Build the body.
      case (kind)
        LK_NOISE: begin
          repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        LK_MANY_FIELDS: begin
          // 30 to 34 separators; 32 or more run past the field limit.
          line_bytes.push_back(CH_START);
          repeat ($urandom_range(30, 34)) begin
            if ($urandom_range(0, 1)) add_body(field_char());
            add_body(CH_SEP);
          end
        end
        LK_LONG: begin
          // Straddle the buffer end; often put a separator on the last slot.
          line_bytes.push_back(CH_START);
          body_len = $urandom_range(124, 131);
          for (int k = 0; k < body_len; k++)
            add_body(((k == 127 && $urandom_range(0, 1)) || $urandom_range(0, 7) == 0) ?
                     CH_SEP : field_char());
        end
        default: begin
          line_bytes.push_back(CH_START);
          nfields = $urandom_range(1, 6);
          for (int f = 0; f < nfields; f++) begin
            if (f > 0) add_body(CH_SEP);
            repeat ($urandom_range(0, 8)) add_body(field_char());
          end
        end
      endcase

      // Close the sentence.
      if (kind == LK_PLAIN) begin
        line_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
      end else if (kind == LK_BAD_DIGIT) begin
        line_bytes.push_back(CH_STAR);
        if ($urandom_range(0, 1)) begin
          line_bytes.push_back(non_hex_char());
        end else begin
          line_bytes.push_back(hex_char(line_sum[7:4]));
          line_bytes.push_back(non_hex_char());
        end
      end else if (kind != LK_NOISE) begin
        sent_sum = (kind == LK_WRONG_SUM) ? line_sum ^ 8'($urandom_range(1, 255)) : line_sum;
        line_bytes.push_back(CH_STAR);
        line_bytes.push_back(hex_char(sent_sum[7:4]));
        line_bytes.push_back(hex_char(sent_sum[3:0]));
        if ($urandom_range(0, 1)) begin
          line_bytes.push_back(CH_CR);
          line_bytes.push_back(CH_LF);
        end
      end

      foreach (line_bytes[k]) send_rx_byte(line_bytes[k]);
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every outstanding result, then let the pipeline settle.
    while (awaited_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Drove %0d bytes: %0d checksummed, %0d CR/LF-ended, %0d wrong-sum, %0d bad-digit,",
             bytes_sent, line_tally[LK_CHECKED], line_tally[LK_PLAIN],
             line_tally[LK_WRONG_SUM], line_tally[LK_BAD_DIGIT]);
    $display("  %0d too-many-field and %0d buffer-filling lines, %0d noise bursts; %0d results.",
             line_tally[LK_MANY_FIELDS], line_tally[LK_LONG], line_tally[LK_NOISE],
             checked_count);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/nsp_pkg.sv
hw/rtl/nsp_char_decode.sv
hw/rtl/nsp_parse_core.sv
hw/rtl/nsp_out_stage.sv
hw/rtl/nmea_sentence_parser_top.sv
tb/nmea_result_checker.sv
tb/nmea_sentence_parser_top_test.sv
